// ===== rtl/core/edf_pkg.sv =====
package edf_pkg;

  // Default configuration
  localparam int NUM_TASKS_DEF = 8;
  localparam int TIME_BITS_DEF = 32;

  // Field widths of one input item and one result item
  localparam int SLOT_W  = 3;
  localparam int VAL_W   = 16;
  localparam int MASK_W  = 8;
  localparam int TOTAL_W = 32;

  // Stream payload widths (packed, zero filled to whole bytes)
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

  // Item kinds carried in tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Control sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SWEEP  = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_OUT    = 4'b1000
  } state_e;

  // Flags of the search token that walks the cell chain
  typedef struct packed {
    logic valid;     // token carries a live search
    logic any_left;  // some slot seen so far has work or instances left
    logic found;     // some slot seen so far has work left
    logic adj;       // current best would miss only because of its own last unit
  } sweep_flags_t;

endpackage

// ===== rtl/core/edf_cell.sv =====
module edf_cell
  import edf_pkg::*;
#(
  parameter int CELL_IDX  = 0,
  parameter int IDX_W     = 3,
  parameter int CNT_W     = 4,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // load broadcast
  input  logic                 load_en_i,
  input  logic [SLOT_W-1:0]    load_slot_i,
  input  logic [VAL_W-1:0]     load_exec_i,
  input  logic [VAL_W-1:0]     load_period_i,
  input  logic [VAL_W-1:0]     load_count_i,
  // commit broadcast
  input  logic                 commit_i,
  input  logic                 win_found_i,
  input  logic [IDX_W-1:0]     win_idx_i,
  input  logic [TIME_BITS-1:0] now_i,
  // search token from the previous cell
  input  sweep_flags_t         tok_flags_i,
  input  logic [IDX_W-1:0]     tok_idx_i,
  input  logic [TIME_BITS-1:0] tok_dl_i,
  input  logic [CNT_W-1:0]     tok_cnt_i,
  // search token to the next cell
  output sweep_flags_t         tok_flags_o,
  output logic [IDX_W-1:0]     tok_idx_o,
  output logic [TIME_BITS-1:0] tok_dl_o,
  output logic [CNT_W-1:0]     tok_cnt_o,
  output logic                 miss_o
);

  logic [VAL_W-1:0]     wl_q, wl_d;
  logic [VAL_W-1:0]     inst_q, inst_d;
  logic [VAL_W-1:0]     exec_q, exec_d;
  logic [VAL_W-1:0]     per_q, per_d;
  logic [TIME_BITS-1:0] dl_q, dl_d;

  sweep_flags_t         flags_q, flags_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [TIME_BITS-1:0] bdl_q, bdl_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic                 wl_nz, hit, take, load_hit, is_win;
  logic [VAL_W-1:0]     wl_dec;

  assign wl_nz    = (wl_q != '0);
  assign hit      = (dl_q == now_i) && (inst_q != '0);
  assign load_hit = load_en_i && (CELL_IDX < 8) && (load_slot_i == SLOT_W'(CELL_IDX));
  assign is_win   = win_found_i && (win_idx_i == IDX_W'(CELL_IDX));
  assign wl_dec   = is_win ? (wl_q - VAL_W'(1)) : wl_q;
  assign miss_o   = commit_i && hit && (wl_dec != '0);

  // Fold this slot into the passing token
  assign take = tok_flags_i.valid && wl_nz && (!tok_flags_i.found || (dl_q < tok_dl_i));

  always_comb begin
    flags_d.valid    = tok_flags_i.valid;
    flags_d.any_left = tok_flags_i.any_left || wl_nz || (inst_q != '0);
    flags_d.found    = tok_flags_i.found || wl_nz;
    flags_d.adj      = take ? (hit && (wl_q == VAL_W'(1))) : tok_flags_i.adj;
    idx_d            = take ? IDX_W'(CELL_IDX) : tok_idx_i;
    bdl_d            = take ? dl_q : tok_dl_i;
    cnt_d            = tok_cnt_i + CNT_W'(hit && wl_nz);
  end

  // Slot state update: load or end-of-tick commit
  always_comb begin
    wl_d   = wl_q;
    inst_d = inst_q;
    exec_d = exec_q;
    per_d  = per_q;
    dl_d   = dl_q;
    if (load_hit) begin
      exec_d = load_exec_i;
      per_d  = load_period_i;
      inst_d = load_count_i;
      wl_d   = load_exec_i;
      dl_d   = TIME_BITS'(load_period_i);
    end else if (commit_i) begin
      wl_d = wl_dec;
      if (hit) begin
        wl_d   = (inst_q > VAL_W'(1)) ? exec_q : '0;
        dl_d   = dl_q + TIME_BITS'(per_q);
        inst_d = inst_q - VAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q    <= '0;
      inst_q  <= '0;
      exec_q  <= '0;
      per_q   <= '0;
      dl_q    <= '0;
      flags_q <= '0;
    end else begin
      wl_q    <= wl_d;
      inst_q  <= inst_d;
      exec_q  <= exec_d;
      per_q   <= per_d;
      dl_q    <= dl_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    bdl_q <= bdl_d;
    cnt_q <= cnt_d;
  end

  assign tok_flags_o = flags_q;
  assign tok_idx_o   = idx_q;
  assign tok_dl_o    = bdl_q;
  assign tok_cnt_o   = cnt_q;

endmodule

// ===== rtl/core/edf_periodic_task_scheduler.sv =====
// Channel  Dir  Handshake                Payload
// s_axis   in   s_axis_tvalid/tready     tuser: op; tdata: slot, exec, period, count
// m_axis   out  m_axis_tvalid/tready     tdata: run slot, busy, switch, miss mask,
//                                        miss total, all done
//
// Each item runs in steps from acceptance to the next acceptance: a search token walks the
// chain of task cells, one cell per cycle, and the search outcome is latched; a tick with
// work or instances left then commits, updating all cells at once (a load, or a tick with
// nothing left, skips the commit); the result is handed to the output register, and the
// idle state holds tready high for the next item.
// Reset clears all slots, sets time to one and the last running task to idle.
// A held result stalls the sequencer only at its hand-off; input is taken again
// as soon as the result is parked in the output register.
module edf_periodic_task_scheduler
  import edf_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [2:0] task_slot, [18:3] exec_time, [34:19] period, [50:35] instance_count
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] op
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [2:0] running_slot, [3] cpu_busy, [4] switched, [12:5] miss_mask,
  // [44:13] miss_total, [45] all_done
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W = $clog2(NUM_TASKS + 1);

  state_e state_q, state_d;

  logic                 in_acc, out_free;
  logic                 load_en;
  logic [SLOT_W-1:0]    in_slot;
  logic [VAL_W-1:0]     in_exec, in_period, in_count, load_period;

  logic                 op_q;
  logic                 start_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TOTAL_W-1:0]   misses_q;
  logic                 last_busy_q;
  logic [IDX_W-1:0]     last_idx_q;

  // search outcome held for the commit cycle
  logic                 win_found_q;
  logic [IDX_W-1:0]     win_idx_q;
  logic [CNT_W-1:0]     win_cnt_q;
  logic                 commit;

  // result waiting for the output register
  logic [SLOT_W-1:0]    res_run_q;
  logic                 res_busy_q, res_sw_q, res_done_q;
  logic [MASK_W-1:0]    res_mask_q, mask_now;
  logic [TOTAL_W-1:0]   res_total_q;

  // output register
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // token chain
  sweep_flags_t         tok_flags [NUM_TASKS+1];
  logic [IDX_W-1:0]     tok_idx   [NUM_TASKS+1];
  logic [TIME_BITS-1:0] tok_dl    [NUM_TASKS+1];
  logic [CNT_W-1:0]     tok_cnt   [NUM_TASKS+1];
  logic [NUM_TASKS-1:0] miss;

  sweep_flags_t         last_tok;
  logic                 sweep_done, tick_live;
  logic [TOTAL_W:0]     miss_sum;
  logic                 sw_now;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign in_slot   = s_axis_tdata_i[2:0];
  assign in_exec   = s_axis_tdata_i[18:3];
  assign in_period = s_axis_tdata_i[34:19];
  assign in_count  = s_axis_tdata_i[50:35];

  // a zero period is stored as one
  assign load_period = (in_period == '0) ? VAL_W'(1) : in_period;
  assign load_en     = in_acc && (s_axis_tuser_i == OP_LOAD);
  assign commit      = (state_q == ST_COMMIT);

  // Launch an empty token into the head of the chain
  assign tok_flags[0] = '{valid: start_q, any_left: 1'b0, found: 1'b0, adj: 1'b0};
  assign tok_idx[0]   = '0;
  assign tok_dl[0]    = '0;
  assign tok_cnt[0]   = '0;

  for (genvar k = 0; k < NUM_TASKS; k++) begin : g_cell
    edf_cell #(
      .CELL_IDX  (k),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .load_en_i     (load_en),
      .load_slot_i   (in_slot),
      .load_exec_i   (in_exec),
      .load_period_i (load_period),
      .load_count_i  (in_count),
      .commit_i      (commit),
      .win_found_i   (win_found_q),
      .win_idx_i     (win_idx_q),
      .now_i         (now_q),
      .tok_flags_i   (tok_flags[k]),
      .tok_idx_i     (tok_idx[k]),
      .tok_dl_i      (tok_dl[k]),
      .tok_cnt_i     (tok_cnt[k]),
      .tok_flags_o   (tok_flags[k+1]),
      .tok_idx_o     (tok_idx[k+1]),
      .tok_dl_o      (tok_dl[k+1]),
      .tok_cnt_o     (tok_cnt[k+1]),
      .miss_o        (miss[k])
    );
  end

  // Gather the per-slot miss flags of the first eight slots
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < NUM_TASKS) begin : g_on
      assign mask_now[b] = miss[b];
    end else begin : g_off
      assign mask_now[b] = 1'b0;
    end
  end

  assign last_tok   = tok_flags[NUM_TASKS];
  assign sweep_done = (state_q == ST_SWEEP) && last_tok.valid;
  assign tick_live  = (op_q == OP_TICK) && last_tok.any_left;

  // saturating add of this tick's misses
  assign miss_sum = {1'b0, misses_q} + (TOTAL_W + 1)'(win_cnt_q);
  assign sw_now   = (win_found_q != last_busy_q) || (win_found_q && (win_idx_q != last_idx_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_SWEEP;
      ST_SWEEP:  if (last_tok.valid) state_d = tick_live ? ST_COMMIT : ST_OUT;
      ST_COMMIT: state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      now_q       <= TIME_BITS'(1);
      misses_q    <= '0;
      last_busy_q <= 1'b0;
      last_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_acc;
      if (commit) begin
        // advance time, count misses, remember who ran
        now_q       <= now_q + TIME_BITS'(1);
        misses_q    <= miss_sum[TOTAL_W] ? '1 : miss_sum[TOTAL_W-1:0];
        last_busy_q <= win_found_q;
        last_idx_q  <= win_idx_q;
      end
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= s_axis_tuser_i;
    end
    if (sweep_done) begin
      // drop the winner's own last unit from the miss count
      win_found_q <= last_tok.found;
      win_idx_q   <= last_tok.found ? tok_idx[NUM_TASKS] : '0;
      win_cnt_q   <= tok_cnt[NUM_TASKS] - CNT_W'(last_tok.found && last_tok.adj);
      res_run_q   <= '0;
      res_busy_q  <= 1'b0;
      res_sw_q    <= 1'b0;
      res_mask_q  <= '0;
      res_total_q <= misses_q;
      res_done_q  <= !last_tok.any_left;
    end
    if (commit) begin
      res_run_q   <= SLOT_W'(win_idx_q);
      res_busy_q  <= win_found_q;
      res_sw_q    <= sw_now;
      res_mask_q  <= mask_now;
      res_total_q <= miss_sum[TOTAL_W] ? '1 : miss_sum[TOTAL_W-1:0];
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_data_q <= {2'b00, res_done_q, res_total_q, res_mask_q,
                     res_sw_q, res_busy_q, res_run_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import edf_pkg::*;

  localparam int NUM_SLOTS = 8;
  localparam int RUN_ITEMS = 2000;
  localparam logic [3:0] IDLE_SLOT = 4'd8;

  // One result item, as the block packs it from bit 0 up
  typedef struct packed {
    logic              done;
    logic [TOTAL_W-1:0] total;
    logic [MASK_W-1:0] mask;
    logic              sw;
    logic              busy;
    logic [SLOT_W-1:0] slot;
  } sched_result_t;

  // Scheduler state mirror plus the queue of results still owed by the block
  class sched_checker;
    logic [VAL_W-1:0] work_left [NUM_SLOTS];
    logic [VAL_W-1:0] inst_left [NUM_SLOTS];
    logic [VAL_W-1:0] exec_len [NUM_SLOTS];
    logic [VAL_W-1:0] period_len [NUM_SLOTS];
    logic [31:0]      deadline [NUM_SLOTS];
    logic [31:0]      now_t;
    logic [31:0]      misses;
    logic [3:0]       last_run;
    int               errors;
    sched_result_t    results_due [$];

    function new();
      for (int s = 0; s < NUM_SLOTS; s++) begin
        work_left[s] = '0;
        inst_left[s] = '0;
        exec_len[s] = '0;
        period_len[s] = '0;
        deadline[s] = '0;
      end
      now_t = 32'd1;
      misses = '0;
      last_run = IDLE_SLOT;
      errors = 0;
    endfunction

    function logic nothing_left();
      for (int s = 0; s < NUM_SLOTS; s++)
        if (work_left[s] != 0 || inst_left[s] != 0) return 1'b0;
      return 1'b1;
    endfunction

    function sched_result_t predict_schedule(logic op, logic [SLOT_W-1:0] slot,
                                             logic [VAL_W-1:0] ex, logic [VAL_W-1:0] per,
                                             logic [VAL_W-1:0] cnt);
      sched_result_t r;
      logic          found;
      logic [3:0]    cur;
      r = '0;
      if (op == OP_LOAD) begin
        // A zero period is stored as one; the deadline is one period, not now plus one
        if (per == 0) per = 16'd1;
        exec_len[slot] = ex;
        period_len[slot] = per;
        inst_left[slot] = cnt;
        work_left[slot] = ex;
        deadline[slot] = {16'b0, per};
        r.done = nothing_left();
      end else if (nothing_left()) begin
        r.done = 1'b1;
      end else begin
        // Pick the earliest deadline with work left; strict compare keeps the lowest slot
        found = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (work_left[s] != 0 && (!found || deadline[s] < deadline[r.slot])) begin
            found = 1'b1;
            r.slot = SLOT_W'(s);
          end
        end
        if (found) begin
          r.busy = 1'b1;
          work_left[r.slot]--;
          cur = {1'b0, r.slot};
        end else begin
          r.slot = '0;
          cur = IDLE_SLOT;
        end
        r.sw = (cur != last_run);
        last_run = cur;
        // Retire deadlines that fall on this tick; zero-instance slots never do
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (deadline[s] == now_t && inst_left[s] != 0) begin
            if (work_left[s] != 0) begin
              r.mask[s] = 1'b1;
              work_left[s] = '0;
              if (misses != '1) misses++;
            end
            if (inst_left[s] > 1) work_left[s] = exec_len[s];
            deadline[s] += {16'b0, period_len[s]};
            inst_left[s]--;
          end
        end
        now_t++;
      end
      r.total = misses;
      return r;
    endfunction

    function void note_item(logic op, logic [IN_DATA_W-1:0] d);
      sched_result_t pred;
      pred = predict_schedule(op, d[2:0], d[18:3], d[34:19], d[50:35]);
      results_due = {results_due, pred};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 100)
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task check_result(logic [OUT_DATA_W-1:0] d);
      sched_result_t want;
      if (results_due.size() == 0) begin
        report("result with none pending", d[31:0], 0);
        return;
      end
      want = results_due.pop_front();
      if (d[2:0] != want.slot) report("running_slot", d[2:0], want.slot);
      if (d[3] != want.busy) report("cpu_busy", d[3], want.busy);
      if (d[4] != want.sw) report("switched", d[4], want.sw);
      if (d[12:5] != want.mask) report("miss_mask", d[12:5], want.mask);
      if (d[44:13] != want.total) report("miss_total", d[44:13], want.total);
      if (d[45] != want.done) report("all_done", d[45], want.done);
      if (d[47:46] != 0) report("padding", d[47:46], 0);
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = OP_LOAD;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  sched_checker sb;
  int           items_sent = 0;
  logic         calm;

  // Stretch of the run with no idling on either side
  assign calm = (items_sent >= 900 && items_sent < 1200);

  edf_periodic_task_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      sb.note_item(s_axis_tuser_i, s_axis_tdata_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o);
  end

  // Offer one item from a falling edge, hold it until taken, then maybe idle
  task automatic send_item(logic op, logic [SLOT_W-1:0] slot, logic [VAL_W-1:0] ex,
                           logic [VAL_W-1:0] per, logic [VAL_W-1:0] cnt);
    int r;
    int gap;
    s_axis_tuser_i = op;
    s_axis_tdata_i = {5'b0, cnt, per, ex, slot};
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    @(negedge clk_i);
    if (!calm) begin
      r = $urandom_range(0, 99);
      gap = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(4, 30);
      if (gap > 0) begin
        s_axis_tvalid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Tick with random don't-care payload
  task automatic send_tick();
    send_item(OP_TICK, SLOT_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
              VAL_W'($urandom));
  endtask

  // Result side: random stalls, plus one long hold-off so the input backs up
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && items_sent >= 600) begin
        held = 1;
        m_axis_tready_i = 1'b0;
        repeat (300) @(negedge clk_i);
      end
      if (stall > 0) begin
        m_axis_tready_i = 1'b0;
        stall--;
      end else begin
        m_axis_tready_i = 1'b1;
        if (!calm && $urandom_range(0, 99) < 20)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 50) : $urandom_range(1, 3);
      end
    end
  end

  initial begin
    int pick;
    int n;
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: tick with nothing loaded, then zero period, field extremes,
    // a deadline tie, zero instances with work, misses, and a late load
    send_tick();
    send_item(OP_LOAD, 3'd0, 16'd0, 16'd0, 16'd0);
    send_item(OP_LOAD, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_LOAD, 3'd1, 16'd3, 16'd4, 16'd2);
    send_item(OP_LOAD, 3'd2, 16'd3, 16'd4, 16'd1);
    send_item(OP_LOAD, 3'd3, 16'd2, 16'd0, 16'd0);
    repeat (10) send_tick();
    send_item(OP_LOAD, 3'd7, 16'd0, 16'd1, 16'd0);
    send_item(OP_LOAD, 3'd4, 16'd1, 16'd2, 16'd1);
    repeat (4) send_tick();

    // Random: mostly task sets with deadlines just ahead of the current time
    while (items_sent < RUN_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        n = $urandom_range(1, 4);
        repeat (n)
          send_item(OP_LOAD, SLOT_W'($urandom), VAL_W'($urandom_range(0, 6)),
                    VAL_W'(sb.now_t + $urandom_range(1, 20)),
                    VAL_W'($urandom_range(0, 3)));
        n = $urandom_range(5, 40);
        repeat (n) send_tick();
      end else if (pick < 80) begin
        // Empty every slot so the scheduler reports all done
        for (int s = 0; s < NUM_SLOTS; s++)
          send_item(OP_LOAD, SLOT_W'(s), 16'd0, VAL_W'($urandom), 16'd0);
        n = $urandom_range(1, 3);
        repeat (n) send_tick();
      end else if (pick < 90) begin
        send_item(OP_LOAD, SLOT_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
                  VAL_W'($urandom));
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) send_tick();
      end
    end
    s_axis_tvalid_i = 1'b0;

    // Drain, then give the block time to show any stray result
    while (sb.results_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
